// ----- sv/fpg_pkg.sv -----
`timescale 1ns / 1ps

package fpg_pkg;

   // request and result field widths
   localparam int COUNT_W = 7;
   localparam int VALUE_W = 9;

   // largest run and the largest prime it can reach
   localparam int MAX_COUNT = 64;
   localparam int MAX_PRIME = 311;

   // trial divisor never exceeds sqrt(MAX_PRIME) + 1, square kept one bit wider
   localparam int DIV_W = 5;
   localparam int SQ_W  = VALUE_W + 1;

   localparam logic [VALUE_W-1:0] FIRST_CANDIDATE = VALUE_W'(2);
   localparam logic [DIV_W-1:0]   FIRST_DIVISOR   = DIV_W'(2);
   localparam logic [SQ_W-1:0]    FIRST_SQUARE    = SQ_W'(4);

   // status from the remainder unit to the sequencer
   typedef struct packed {
      logic busy;
      logic done;
      logic rem_zero;
   } rem_status_type;

endpackage

// ----- sv/fpg_rem_unit.sv -----
`timescale 1ns / 1ps

module fpg_rem_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [fpg_pkg::VALUE_W-1:0]   dividend,
   input  logic [fpg_pkg::DIV_W-1:0]     divisor,
   output fpg_pkg::rem_status_type       status
);
   import fpg_pkg::*;

   logic                busy_ff, busy_in;
   logic [VALUE_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]    div_ff, div_in;
   logic [VALUE_W-1:0]  div_ext;
   logic                below;

   // one compare and subtract per cycle
   assign div_ext = VALUE_W'(div_ff);
   assign below   = rem_ff < div_ext;

   always_comb begin
      busy_in = busy_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         rem_in  = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         if (below) begin
            busy_in = 1'b0;
         end else begin
            rem_in = rem_ff - div_ext;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign status.busy     = busy_ff;
   assign status.done     = busy_ff && below;
   assign status.rem_zero = rem_ff == '0;

endmodule

// ----- sv/first_primes_generator.sv -----
`timescale 1ns / 1ps

// first primes generator
// req channel: one word carries req_prime_count, the number of primes wanted.
//   a count of 0 is taken and gives nothing; counts above 64 are cut to 64.
// rsp channel: one word per prime, ascending from 2, rsp_last_of_run set on
//   the final prime of the run.
// each candidate is tested by trial division with divisors 2 .. floor(sqrt).
//   one shared remainder unit subtracts the divisor once per cycle, so a
//   division takes longer as the quotient grows, and each divisor also
//   passes through the test state; shorter runs finish much sooner than a
//   full run of 64 primes.
// after a request is taken, the first prime passes the test and prime states, then the output register.
// req_ready is high only while no run is in progress; the last word of a run
//   may still sit in the output register while the next request is taken.
// when the receiver stalls, the found prime waits in the output register and
//   the search continues up to the next prime, then holds there.
// reset is synchronous and drops any run and any pending word.

module first_primes_generator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [fpg_pkg::COUNT_W-1:0]   req_prime_count,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [fpg_pkg::VALUE_W-1:0]   rsp_prime_value,
   output logic                          rsp_last_of_run
);
   import fpg_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_TEST  = 2'd1;
   localparam logic [1:0] S_DIV   = 2'd2;
   localparam logic [1:0] S_PRIME = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [COUNT_W-1:0]  want_ff, want_in;
   logic [COUNT_W-1:0]  got_ff, got_in;
   logic [VALUE_W-1:0]  cand_ff, cand_in;
   logic [DIV_W-1:0]    div_ff, div_in;
   logic [SQ_W-1:0]     sq_ff, sq_in;
   logic                out_valid_ff, out_valid_in;
   logic [VALUE_W-1:0]  out_value_ff, out_value_in;
   logic                out_last_ff, out_last_in;

   logic                req_take;
   logic                out_free;
   logic [COUNT_W-1:0]  want_sat;
   logic [COUNT_W-1:0]  got_next;
   logic                sq_over;
   logic                rem_start;
   rem_status_type      rem_st;

   // shared remainder unit
   fpg_rem_unit u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (cand_ff),
      .divisor  (div_ff),
      .status   (rem_st)
   );

   assign req_ready = state_ff == S_IDLE;
   assign req_take  = req_valid && req_ready;
   assign out_free  = !out_valid_ff || rsp_ready;
   assign want_sat  = (req_prime_count > COUNT_W'(MAX_COUNT)) ?
                      COUNT_W'(MAX_COUNT) : req_prime_count;
   assign got_next  = got_ff + COUNT_W'(1);
   // divisor squared past the candidate: no divisor left, so it is prime
   assign sq_over   = sq_ff > SQ_W'(cand_ff);
   assign rem_start = (state_ff == S_TEST) && !sq_over;

   always_comb begin
      state_in     = state_ff;
      want_in      = want_ff;
      got_in       = got_ff;
      cand_in      = cand_ff;
      div_in       = div_ff;
      sq_in        = sq_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_value_in = out_value_ff;
      out_last_in  = out_last_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               want_in = want_sat;
               got_in  = '0;
               cand_in = FIRST_CANDIDATE;
               div_in  = FIRST_DIVISOR;
               sq_in   = FIRST_SQUARE;
               if (want_sat != '0) begin
                  state_in = S_TEST;
               end
            end
         end
         S_TEST: begin
            if (sq_over) begin
               state_in = S_PRIME;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (rem_st.done) begin
               state_in = S_TEST;
               if (rem_st.rem_zero) begin
                  // composite, move to the next candidate
                  cand_in = cand_ff + VALUE_W'(1);
                  div_in  = FIRST_DIVISOR;
                  sq_in   = FIRST_SQUARE;
               end else begin
                  // (d+1)^2 = d^2 + 2d + 1
                  div_in = div_ff + DIV_W'(1);
                  sq_in  = sq_ff + SQ_W'({div_ff, 1'b0}) + SQ_W'(1);
               end
            end
         end
         S_PRIME: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_value_in = cand_ff;
               out_last_in  = got_next == want_ff;
               got_in       = got_next;
               cand_in      = cand_ff + VALUE_W'(1);
               div_in       = FIRST_DIVISOR;
               sq_in        = FIRST_SQUARE;
               if (got_next == want_ff) begin
                  state_in = S_IDLE;
               end else begin
                  state_in = S_TEST;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         want_ff      <= '0;
         got_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         want_ff      <= want_in;
         got_ff       <= got_in;
         out_valid_ff <= out_valid_in;
      end
      cand_ff      <= cand_in;
      div_ff       <= div_in;
      sq_ff        <= sq_in;
      out_value_ff <= out_value_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_prime_value = out_value_ff;
   assign rsp_last_of_run = out_last_ff;

`ifndef SYNTHESIS
   // the run count never passes the requested count
   a_got_bounded: assert property (@(posedge clock) disable iff (reset)
      got_ff <= want_ff)
      else $error("prime count passed request");

   // the sequencer waits on the divider only while it is running
   a_div_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> rem_st.busy)
      else $error("waiting on idle remainder unit");

   // a pending last word with a new run under way means nothing was emitted yet
   a_last_pending: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_last_ff && state_ff != S_IDLE) |-> got_ff == '0)
      else $error("new run emitted past a pending last word");

   // candidates stay within the range of the largest run
   a_cand_range: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> cand_ff <= VALUE_W'(MAX_PRIME))
      else $error("candidate out of range");

   // every emitted word is at least the first prime
   a_value_floor: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_value_ff >= FIRST_CANDIDATE)
      else $error("emitted value below two");
`endif

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

   import fpg_pkg::*;

   // generous bound: several times a run where every request asks for 64 primes
   localparam int CYCLE_LIMIT   = 30_000_000;
   localparam int IDLE_PCT      = 22;
   localparam int HOLD_CYCLES   = 600;
   localparam int DRAIN_CYCLES  = 40;
   localparam int RANDOM_ITEMS  = 100;

   // one expected word on the rsp channel
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               last;
   } prime_word_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [COUNT_W-1:0]   req_prime_count = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [VALUE_W-1:0]   rsp_prime_value;
   logic                 rsp_last_of_run;

   logic [COUNT_W-1:0]   counts_pending[$];   // requests not yet offered
   prime_word_type       primes_due[$];       // predicted words still to arrive

   int unsigned          cycle_cnt     = 0;
   int unsigned          err_cnt       = 0;
   int unsigned          reqs_taken    = 0;
   int unsigned          words_checked = 0;
   int unsigned          zero_reqs     = 0;
   int unsigned          capped_reqs   = 0;
   int unsigned          hold_left     = 0;
   bit                   hold_done     = 1'b0;
   bit                   calm_tx;
   bit                   calm_rx;

   first_primes_generator u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_prime_count (req_prime_count),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_prime_value (rsp_prime_value),
      .rsp_last_of_run (rsp_last_of_run)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // expand one request into the primes it should produce, trial division
   // by every divisor whose square does not pass the candidate
   function automatic void predict_primes(input logic [COUNT_W-1:0] count);
      int unsigned    want;
      int unsigned    found;
      int unsigned    cand;
      int unsigned    div;
      bit             clean;
      prime_word_type w;
      want  = (count > MAX_COUNT) ? MAX_COUNT : count;
      found = 0;
      cand  = 2;
      while (found < want) begin
         clean = 1'b1;
         for (div = 2; div * div <= cand; div++) begin
            if (cand % div == 0) clean = 1'b0;
         end
         if (clean) begin
            w.value = cand[VALUE_W-1:0];
            w.last  = (found + 1 == want);
            primes_due.push_back(w);
            found++;
         end
         cand++;
      end
   endfunction

   // stretches with no idling on either side
   assign calm_tx = (reqs_taken >= 45) && (reqs_taken < 65);
   assign calm_rx = (words_checked >= 300) && (words_checked < 700);

   // sender: offer the next pending count, idling now and then
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_primes(req_prime_count);
            reqs_taken++;
            if (req_prime_count == 0) zero_reqs++;
            if (req_prime_count > MAX_COUNT) capped_reqs++;
         end
         // valid holds with a stable word until it is taken
         if (!req_valid || req_ready) begin
            if (counts_pending.size() > 0 &&
                (calm_tx || $urandom_range(99) >= IDLE_PCT)) begin
               req_valid       <= 1'b1;
               req_prime_count <= counts_pending.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: check each taken word against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (primes_due.size() == 0) begin
               $error("unexpected word: prime_value %0d last_of_run %0b",
                      rsp_prime_value, rsp_last_of_run);
               err_cnt++;
            end else begin
               if (rsp_prime_value !== primes_due[0].value) begin
                  $error("prime_value mismatch: expected %0d, got %0d",
                         primes_due[0].value, rsp_prime_value);
                  err_cnt++;
               end
               if (rsp_last_of_run !== primes_due[0].last) begin
                  $error("last_of_run mismatch: expected %0b, got %0b",
                         primes_due[0].last, rsp_last_of_run);
                  err_cnt++;
               end
               void'(primes_due.pop_front());
            end
            words_checked++;
         end
         // one long hold-off so the block backs up and stalls req
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (!hold_done && words_checked >= 60) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm_rx || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still due",
                  cycle_cnt, primes_due.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      int r;
      int total_reqs;
      // directed: zero, one, smallest runs, the cap, just past it, all ones,
      // and a few odd bit patterns
      counts_pending.push_back(7'd0);
      counts_pending.push_back(7'd1);
      counts_pending.push_back(7'd2);
      counts_pending.push_back(7'd3);
      counts_pending.push_back(7'd64);
      counts_pending.push_back(7'd65);
      counts_pending.push_back(7'd127);
      counts_pending.push_back(7'd0);
      counts_pending.push_back(7'd63);
      counts_pending.push_back(7'd5);
      counts_pending.push_back(7'd0);
      counts_pending.push_back(7'd100);
      counts_pending.push_back(7'd96);
      counts_pending.push_back(7'd31);
      counts_pending.push_back(7'd1);
      counts_pending.push_back(7'd42);
      // random: mostly short runs, a few long and saturated ones
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         r = $urandom_range(99);
         if (r < 55)      counts_pending.push_back($urandom_range(12, 0));
         else if (r < 80) counts_pending.push_back($urandom_range(40, 13));
         else if (r < 90) counts_pending.push_back($urandom_range(64, 41));
         else             counts_pending.push_back($urandom_range(127, 65));
      end
      total_reqs = counts_pending.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // all requests taken, then every predicted word seen
      while (reqs_taken < total_reqs) @(posedge clock);
      while (primes_due.size() > 0) @(posedge clock);
      // catch any stray word after the last run
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d requests (%0d zero, %0d above the cap)",
               reqs_taken, zero_reqs, capped_reqs);
      $display("checked %0d prime words in %0d cycles", words_checked, cycle_cnt);
      if (err_cnt == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
sv/fpg_pkg.sv
sv/fpg_rem_unit.sv
sv/first_primes_generator.sv
tb/sv/tb_top.sv
